/* src/fixed_point_q24_8_alu_assert.svh */
// assertion macros for the fixed-point alu
// used by the top level; expects clk and arst_n in scope
`ifndef FIXED_POINT_Q24_8_ALU_ASSERT_SVH
`define FIXED_POINT_Q24_8_ALU_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define FPA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fixed-point alu assertion failed");

// next-cycle implication, disabled while in reset
`define FPA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fixed-point alu assertion failed");

`endif

/* src/fpa_pkg.sv */
// shared constants, opcodes and types for the fixed-point alu
// no dependencies
package fpa_pkg;

	localparam int DATA_W = 32;
	localparam int OP_W = 4;
	localparam int FRACTION_BITS_DEF = 8;

	localparam logic [OP_W-1:0] OP_ADD      = 4'd0;
	localparam logic [OP_W-1:0] OP_SUB      = 4'd1;
	localparam logic [OP_W-1:0] OP_MUL      = 4'd2;
	localparam logic [OP_W-1:0] OP_DIV      = 4'd3;
	localparam logic [OP_W-1:0] OP_GT       = 4'd4;
	localparam logic [OP_W-1:0] OP_LT       = 4'd5;
	localparam logic [OP_W-1:0] OP_GE       = 4'd6;
	localparam logic [OP_W-1:0] OP_LE       = 4'd7;
	localparam logic [OP_W-1:0] OP_EQ       = 4'd8;
	localparam logic [OP_W-1:0] OP_NE       = 4'd9;
	localparam logic [OP_W-1:0] OP_MIN      = 4'd10;
	localparam logic [OP_W-1:0] OP_MAX      = 4'd11;
	localparam logic [OP_W-1:0] OP_INC      = 4'd12;
	localparam logic [OP_W-1:0] OP_DEC      = 4'd13;
	localparam logic [OP_W-1:0] OP_TO_INT   = 4'd14;
	localparam logic [OP_W-1:0] OP_FROM_INT = 4'd15;

	// per-item side data that rides along the divider stages
	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] res;
		logic              flag;
		logic              dz;
		logic              neg;
	} fpa_side_t;

	function automatic logic [DATA_W-1:0] apply_sign(input logic [DATA_W-1:0] mag,
		input logic neg);
		return neg ? (DATA_W'(0) - mag) : mag;
	endfunction

endpackage

/* src/fpa_front.sv */
// first stage: decode, magnitudes, compares and the operations that need no multiplier or divider
// depends on fpa_pkg
module fpa_front #(
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [fpa_pkg::OP_W-1:0]       req_type,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
	output fpa_pkg::fpa_side_t             side_s1,
	output logic [fpa_pkg::DATA_W-1:0]     mag_a_s1,
	output logic [fpa_pkg::DATA_W-1:0]     mag_b_s1
);

	logic [fpa_pkg::DATA_W-1:0] ua, ub, mag_a, mag_b;
	logic lt, eq, gt;
	fpa_pkg::fpa_side_t side;

	assign ua = operand_a;
	assign ub = operand_b;
	assign mag_a = fpa_pkg::apply_sign(ua, ua[fpa_pkg::DATA_W-1]);
	assign mag_b = fpa_pkg::apply_sign(ub, ub[fpa_pkg::DATA_W-1]);
	assign lt = operand_a < operand_b;
	assign eq = ua == ub;
	assign gt = !lt && !eq;

	always_comb begin
		side.op = req_type;
		side.res = '0;
		side.flag = 1'b0;
		side.dz = (req_type == fpa_pkg::OP_DIV) && (ub == '0);
		side.neg = ua[fpa_pkg::DATA_W-1] ^ ub[fpa_pkg::DATA_W-1];
		case (req_type)
			fpa_pkg::OP_ADD:      side.res = ua + ub;
			fpa_pkg::OP_SUB:      side.res = ua - ub;
			fpa_pkg::OP_GT:       side.flag = gt;
			fpa_pkg::OP_LT:       side.flag = lt;
			fpa_pkg::OP_GE:       side.flag = !lt;
			fpa_pkg::OP_LE:       side.flag = lt || eq;
			fpa_pkg::OP_EQ:       side.flag = eq;
			fpa_pkg::OP_NE:       side.flag = !eq;
			fpa_pkg::OP_MIN:      side.res = lt ? ua : ub;
			fpa_pkg::OP_MAX:      side.res = gt ? ua : ub;
			fpa_pkg::OP_INC:      side.res = ua + fpa_pkg::DATA_W'(1);
			fpa_pkg::OP_DEC:      side.res = ua - fpa_pkg::DATA_W'(1);
			fpa_pkg::OP_TO_INT:
				side.res = fpa_pkg::apply_sign(mag_a >> FRACTION_BITS, ua[fpa_pkg::DATA_W-1]);
			fpa_pkg::OP_FROM_INT: side.res = ua << FRACTION_BITS;
			default:              side.res = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s1 <= side;
			mag_a_s1 <= mag_a;
			mag_b_s1 <= mag_b;
		end
	end

endmodule

/* src/fpa_mul.sv */
// registered 32x32 magnitude multiplier, keeps the scaled low word
// depends on fpa_pkg
module fpa_mul #(
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       en,
	input  logic [fpa_pkg::DATA_W-1:0] mag_a,
	input  logic [fpa_pkg::DATA_W-1:0] mag_b,
	output logic [fpa_pkg::DATA_W-1:0] prod_s2
);

	logic [2*fpa_pkg::DATA_W-1:0] prod;

	assign prod = {{fpa_pkg::DATA_W{1'b0}}, mag_a} * {{fpa_pkg::DATA_W{1'b0}}, mag_b};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= prod[FRACTION_BITS +: fpa_pkg::DATA_W];
		end
	end

endmodule

/* src/fpa_div.sv */
// pipelined restoring divider, two quotient bits per stage
// depends on fpa_pkg; stage enables come from the top level
module fpa_div #(
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF,
	localparam int DVD_W = fpa_pkg::DATA_W + FRACTION_BITS,
	localparam int STAGES = (DVD_W + 1) / 2
) (
	input  logic                       clk,
	input  logic [STAGES-1:0]          en,
	input  logic [fpa_pkg::DATA_W-1:0] mag_a,
	input  logic [fpa_pkg::DATA_W-1:0] mag_b,
	output logic [fpa_pkg::DATA_W-1:0] quo
);

	localparam int X_W = 2 * STAGES;
	localparam int W = fpa_pkg::DATA_W;

	logic [W-1:0]   rem_s [STAGES];
	logic [X_W-1:0] x_s   [STAGES];
	logic [W-1:0]   d_s   [STAGES];
	logic [X_W-1:0] dvd;

	// x holds the dividend bits still to go, quotient bits shift in from the bottom
	function automatic logic [W+X_W-1:0] div_step(input logic [W-1:0] rem,
		input logic [X_W-1:0] x, input logic [W-1:0] d);
		logic [W:0] r2;
		logic ge;
		r2 = {rem, x[X_W-1]};
		ge = r2 >= {1'b0, d};
		return {(ge ? W'(r2 - {1'b0, d}) : r2[W-1:0]), x[X_W-2:0], ge};
	endfunction

	assign dvd = X_W'({mag_a, {FRACTION_BITS{1'b0}}});

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [W-1:0]   rem_in;
		logic [X_W-1:0] x_in;
		logic [W-1:0]   d_in;
		logic [W+X_W-1:0] st1, st2;

		if (g == 0) begin : g_first
			assign rem_in = '0;
			assign x_in = dvd;
			assign d_in = mag_b;
		end else begin : g_next
			assign rem_in = rem_s[g-1];
			assign x_in = x_s[g-1];
			assign d_in = d_s[g-1];
		end

		assign st1 = div_step(rem_in, x_in, d_in);
		assign st2 = div_step(st1[W+X_W-1:X_W], st1[X_W-1:0], d_in);

		always_ff @(posedge clk) begin
			if (en[g]) begin
				rem_s[g] <= st2[W+X_W-1:X_W];
				x_s[g] <= st2[X_W-1:0];
				d_s[g] <= d_in;
			end
		end
	end

	assign quo = x_s[STAGES-1][W-1:0];

endmodule

/* src/fixed_point_q24_8_alu.sv */
// channel | signals                                       | dir
// in      | in_valid, in_stall, req_type, operand_a, b    | request beat in
// out     | out_valid, out_stall, result_value, flag, st  | result beat out
// one beat per cycle unless a stall holds the pipe; the pipeline depth is
// set by the divider, which resolves two quotient bits per stage
// all operations take the same path, so results leave in request order
// arst_n clears only the stage valid bits
// a stall holds a stage only when the stage after it is full and held, bubbles collapse
// top level of the fixed-point alu; depends on fpa_pkg, fpa_front, fpa_mul, fpa_div
module fixed_point_q24_8_alu #(
	parameter int FRACTION_BITS = fpa_pkg::FRACTION_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [fpa_pkg::OP_W-1:0]          req_type,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_a,
	input  logic signed [fpa_pkg::DATA_W-1:0] operand_b,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [fpa_pkg::DATA_W-1:0] result_value,
	output logic                              compare_flag,
	output logic                              status
);

	`include "fixed_point_q24_8_alu_assert.svh"

	localparam int DVD_W = fpa_pkg::DATA_W + FRACTION_BITS;
	localparam int STAGES = (DVD_W + 1) / 2;
	localparam int NST = STAGES + 2;

	logic [NST-1:0] v_q;
	logic [NST-1:0] en;

	fpa_pkg::fpa_side_t         side_s1;
	logic [fpa_pkg::DATA_W-1:0] mag_a_s1, mag_b_s1, prod_s2, quo;
	fpa_pkg::fpa_side_t         side_p [STAGES];
	logic [fpa_pkg::DATA_W-1:0] mul_p  [STAGES];
	fpa_pkg::fpa_side_t         last;
	logic [fpa_pkg::DATA_W-1:0] res_d;
	logic [fpa_pkg::OP_W-1:0]   out_op_q;

	// stage advances when empty or when the next one advances
	assign en[NST-1] = !v_q[NST-1] || !out_stall;
	for (genvar i = 0; i < NST-1; i++) begin : g_en
		assign en[i] = !v_q[i] || en[i+1];
	end

	assign in_stall = !en[0];
	assign out_valid = v_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	fpa_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
		.clk       (clk),
		.en        (en[0]),
		.req_type  (req_type),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.side_s1   (side_s1),
		.mag_a_s1  (mag_a_s1),
		.mag_b_s1  (mag_b_s1)
	);

	fpa_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
		.clk     (clk),
		.en      (en[1]),
		.mag_a   (mag_a_s1),
		.mag_b   (mag_b_s1),
		.prod_s2 (prod_s2)
	);

	fpa_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
		.clk   (clk),
		.en    (en[STAGES:1]),
		.mag_a (mag_a_s1),
		.mag_b (mag_b_s1),
		.quo   (quo)
	);

	// side data and product ride alongside the divider stages
	assign mul_p[0] = prod_s2;
	always_ff @(posedge clk) begin
		if (en[1]) begin
			side_p[0] <= side_s1;
		end
	end
	for (genvar g = 1; g < STAGES; g++) begin : g_carry
		always_ff @(posedge clk) begin
			if (en[g+1]) begin
				side_p[g] <= side_p[g-1];
				mul_p[g] <= mul_p[g-1];
			end
		end
	end

	assign last = side_p[STAGES-1];

	always_comb begin
		case (last.op)
			fpa_pkg::OP_MUL: res_d = fpa_pkg::apply_sign(mul_p[STAGES-1], last.neg);
			fpa_pkg::OP_DIV: res_d = last.dz ? '0 : fpa_pkg::apply_sign(quo, last.neg);
			default:         res_d = last.res;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en[NST-1]) begin
			result_value <= res_d;
			compare_flag <= last.flag;
			status <= last.dz;
			out_op_q <= last.op;
		end
	end

	`FPA_ASSERT_NOW(a_dz_zero, out_valid && status, result_value == '0 && !compare_flag)
	`FPA_ASSERT_NOW(a_dz_op, out_valid && status, out_op_q == fpa_pkg::OP_DIV)
	`FPA_ASSERT_NOW(a_flag_op, out_valid && compare_flag,
		out_op_q == fpa_pkg::OP_GT || out_op_q == fpa_pkg::OP_LT ||
		out_op_q == fpa_pkg::OP_GE || out_op_q == fpa_pkg::OP_LE ||
		out_op_q == fpa_pkg::OP_EQ || out_op_q == fpa_pkg::OP_NE)
	`FPA_ASSERT_NOW(a_stall_full, in_stall, out_valid && out_stall && (&v_q))

endmodule
